[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/hgpg_pkg.sv]
`timescale 1ns / 1ps

package hgpg_pkg;

    // Field widths fixed by the interface.
    localparam int COL_W   = 12;
    localparam int IMG_W   = 13;
    localparam int RGB_W   = 24;
    localparam int PIX_W   = 32;
    localparam int CH_W    = 8;
    localparam int N_CH    = 3;
    localparam int APB_DW  = 32;
    localparam int PADDR_W = 4;

    // Scaled column (column * 255) and blend weight.
    localparam int NUM_W = COL_W + CH_W;
    localparam int T_W   = 8;

    // Weight divider: two quotient bits per stage.
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = T_W / DIV_BITS;

    // Channel blend sum, at most 255 * 255.
    localparam int MIX_W = 16;

    localparam logic [CH_W-1:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [CH_W-1:0]  CH_FULL      = 8'hFF;
    localparam logic [MIX_W-1:0] MIX_MAX      = 16'd65025;

    // Register reset values.
    localparam logic [IMG_W-1:0] WIDTH_RST = 13'd1;
    localparam logic [RGB_W-1:0] LEFT_RST  = 24'h000000;
    localparam logic [RGB_W-1:0] RIGHT_RST = 24'hFFFFFF;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH = 2'd0,
        REG_LEFT_RGB    = 2'd1,
        REG_RIGHT_RGB   = 2'd2
    } t_reg_idx;

    typedef logic [NUM_W-1:0] t_num;
    typedef logic [T_W-1:0]   t_weight;

endpackage

[src/hgpg_tdiv.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hgpg_tdiv import hgpg_pkg::*; #(
    parameter int DEN_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  t_num             i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_vld,
    output t_weight          o_t
);

    localparam int CMP_W = (NUM_W > DEN_W + T_W) ? NUM_W : DEN_W + T_W;
    localparam int LAST  = DIV_STAGES - 1;

    // Front stage: flag quotients that saturate and a zero divisor.
    logic             r_a_vld;
    t_num             r_a_rem;
    logic [DEN_W-1:0] r_a_den;
    logic             r_a_sat;
    logic             r_a_zero;
    logic             n_a_sat;

    assign n_a_sat = CMP_W'(i_num) >= (CMP_W'(i_den) << T_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_rem  <= i_num;
            r_a_den  <= i_den;
            r_a_sat  <= n_a_sat;
            r_a_zero <= (i_den == '0);
        end
    end

    // Restoring division stages, most significant quotient bits first.
    logic             r_vld  [DIV_STAGES];
    t_num             r_rem  [DIV_STAGES];
    logic [DEN_W-1:0] r_den  [DIV_STAGES];
    t_weight          r_q    [DIV_STAGES];
    logic             r_sat  [DIV_STAGES];
    logic             r_zero [DIV_STAGES];

    logic             n_vld  [DIV_STAGES];
    t_num             n_rem  [DIV_STAGES];
    logic [DEN_W-1:0] n_den  [DIV_STAGES];
    t_weight          n_q    [DIV_STAGES];
    logic             n_sat  [DIV_STAGES];
    logic             n_zero [DIV_STAGES];

    always_comb begin
        t_num             v_rem;
        t_weight          v_q;
        logic [DEN_W-1:0] v_den;
        logic [CMP_W-1:0] v_sub;
        for (int j = 0; j < DIV_STAGES; j++) begin
            if (j == 0) begin
                n_vld[j]  = r_a_vld;
                v_rem     = r_a_rem;
                v_q       = '0;
                v_den     = r_a_den;
                n_sat[j]  = r_a_sat;
                n_zero[j] = r_a_zero;
            end else begin
                n_vld[j]  = r_vld[j-1];
                v_rem     = r_rem[j-1];
                v_q       = r_q[j-1];
                v_den     = r_den[j-1];
                n_sat[j]  = r_sat[j-1];
                n_zero[j] = r_zero[j-1];
            end
            for (int b = 0; b < DIV_BITS; b++) begin
                v_sub = CMP_W'(v_den) << (T_W - 1 - DIV_BITS * j - b);
                if (CMP_W'(v_rem) >= v_sub) begin
                    v_rem = v_rem - NUM_W'(v_sub);
                    v_q[T_W - 1 - DIV_BITS * j - b] = 1'b1;
                end
            end
            n_rem[j] = v_rem;
            n_q[j]   = v_q;
            n_den[j] = v_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < DIV_STAGES; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else if (i_en) begin
            for (int j = 0; j < DIV_STAGES; j++) begin
                r_vld[j] <= n_vld[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < DIV_STAGES; j++) begin
                r_rem[j]  <= n_rem[j];
                r_q[j]    <= n_q[j];
                r_den[j]  <= n_den[j];
                r_sat[j]  <= n_sat[j];
                r_zero[j] <= n_zero[j];
            end
        end
    end

    // A width of one gives weight zero; a column past the end gives full weight.
    assign o_vld = r_vld[LAST];
    assign o_t   = r_zero[LAST] ? '0 : (r_sat[LAST] ? '1 : r_q[LAST]);

    `ASSERT_IMPLY(a_first_rem_bound, i_clk, i_rst_n, r_vld[0] && !r_sat[0] && !r_zero[0], CMP_W'(r_rem[0]) < (CMP_W'(r_den[0]) << (T_W - DIV_BITS)), "divider remainder too large after first stage")
    `ASSERT_IMPLY(a_final_rem_bound, i_clk, i_rst_n, r_vld[LAST] && !r_sat[LAST] && !r_zero[LAST], CMP_W'(r_rem[LAST]) < CMP_W'(r_den[LAST]), "divider remainder not below divisor")

endmodule

[src/horizontal_gradient_pixel_generator.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Pipeline: eight register stages, all held while the output is held by i_pixel_ready.
// Throughput: one pixel per cycle while the output is not held; the weight divider
// resolves two quotient bits per stage.
// Reset (synchronous, active low) empties the pipeline and sets width 1, left black, right white.

module horizontal_gradient_pixel_generator import hgpg_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Column requests.
    input  logic               i_column_valid,
    output logic               o_column_ready,
    input  logic [COL_W-1:0]   i_column,
    // Pixel results.
    output logic               o_pixel_valid,
    input  logic               i_pixel_ready,
    output logic [PIX_W-1:0]   o_pixel_argb,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    localparam int DEN_W = $clog2(MAX_WIDTH);
    localparam int WC_W  = (DEN_W + 1 > IMG_W) ? DEN_W + 1 : IMG_W;

    // Configuration registers.
    logic [IMG_W-1:0] r_image_width;
    logic [RGB_W-1:0] r_left_rgb;
    logic [RGB_W-1:0] r_right_rgb;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= WIDTH_RST;
            r_left_rgb    <= LEFT_RST;
            r_right_rgb   <= RIGHT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_IMAGE_WIDTH: r_image_width <= pwdata[IMG_W-1:0];
                REG_LEFT_RGB:    r_left_rgb    <= pwdata[RGB_W-1:0];
                REG_RIGHT_RGB:   r_right_rgb   <= pwdata[RGB_W-1:0];
                default:         ;
            endcase
        end
    end

    // Register read mux.
    always_comb begin
        unique case (paddr[3:2])
            REG_IMAGE_WIDTH: prdata = APB_DW'(r_image_width);
            REG_LEFT_RGB:    prdata = APB_DW'(r_left_rgb);
            REG_RIGHT_RGB:   prdata = APB_DW'(r_right_rgb);
            default:         prdata = '0;
        endcase
    end

    // Pipeline advance: every stage moves unless the output register is held.
    logic r_out_vld;
    logic pipe_en;

    assign pipe_en        = !r_out_vld || i_pixel_ready;
    assign o_column_ready = pipe_en;

    // Stage 1: clamp the width, scale the column by 255.
    logic [WC_W-1:0]  width_ext;
    logic [WC_W-1:0]  width_clamp;
    logic [DEN_W-1:0] n_s1_den;
    t_num             n_s1_num;
    logic             r_s1_vld;
    t_num             r_s1_num;
    logic [DEN_W-1:0] r_s1_den;

    always_comb begin
        width_ext = WC_W'(r_image_width);
        if (width_ext == '0) begin
            width_clamp = WC_W'(1);
        end else if (width_ext > WC_W'(MAX_WIDTH)) begin
            width_clamp = WC_W'(MAX_WIDTH);
        end else begin
            width_clamp = width_ext;
        end
        n_s1_den = DEN_W'(width_clamp - WC_W'(1));
        n_s1_num = {i_column, {CH_W{1'b0}}} - NUM_W'(i_column);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (pipe_en) begin
            r_s1_vld <= i_column_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s1_num <= n_s1_num;
            r_s1_den <= n_s1_den;
        end
    end

    // Stages 2 to 6: blend weight t = num / den, saturated at 255 (zero when den is zero).
    logic    div_vld;
    t_weight div_t;

    hgpg_tdiv #(
        .DEN_W (DEN_W)
    ) u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (r_s1_vld),
        .i_num   (r_s1_num),
        .i_den   (r_s1_den),
        .o_vld   (div_vld),
        .o_t     (div_t)
    );

    // Stage 7: weighted sum of the two colors per channel.
    logic             r_s7_vld;
    logic [MIX_W-1:0] r_mix [N_CH];
    logic [MIX_W-1:0] n_mix [N_CH];

    always_comb begin
        logic [CH_W-1:0] v_lo;
        logic [CH_W-1:0] v_hi;
        for (int c = 0; c < N_CH; c++) begin
            v_lo     = r_left_rgb[CH_W*c +: CH_W];
            v_hi     = r_right_rgb[CH_W*c +: CH_W];
            n_mix[c] = MIX_W'(v_lo) * MIX_W'(CH_FULL - div_t)
                     + MIX_W'(v_hi) * MIX_W'(div_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_vld <= 1'b0;
        end else if (pipe_en) begin
            r_s7_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            for (int c = 0; c < N_CH; c++) begin
                r_mix[c] <= n_mix[c];
            end
        end
    end

    // Stage 8: divide each sum by 255 and pack with opaque alpha.
    logic [PIX_W-1:0] n_pixel;
    logic [PIX_W-1:0] r_pixel;

    always_comb begin
        logic [MIX_W-1:0] v_adj;
        n_pixel = {ALPHA_OPAQUE, {RGB_W{1'b0}}};
        for (int c = 0; c < N_CH; c++) begin
            // Exact floor(x / 255) for x up to 255 * 255.
            v_adj = r_mix[c] + MIX_W'(1) + (r_mix[c] >> CH_W);
            n_pixel[CH_W*c +: CH_W] = v_adj[MIX_W-1 -: CH_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (pipe_en) begin
            r_out_vld <= r_s7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_pixel_valid = r_out_vld;
    assign o_pixel_argb  = r_pixel;

    `ASSERT_NEXT(a_stall_holds_pipe, i_clk, i_rst_n, o_pixel_valid && !i_pixel_ready, $stable(r_s7_vld) && $stable(r_s1_vld), "pipeline moved while output held")
    `ASSERT_IMPLY(a_mix_in_range, i_clk, i_rst_n, r_s7_vld, r_mix[0] <= MIX_MAX && r_mix[1] <= MIX_MAX && r_mix[2] <= MIX_MAX, "channel blend sum out of range")
    `ASSERT_IMPLY(a_width_one_left, i_clk, i_rst_n, o_pixel_valid && r_image_width <= WIDTH_RST, o_pixel_argb[RGB_W-1:0] == r_left_rgb, "single column gradient not left color")

endmodule

[tb/sv/horizontal_gradient_pixel_generator_tb.sv]
`timescale 1ns / 1ps

module horizontal_gradient_pixel_generator_tb;
    import hgpg_pkg::*;

    localparam int MAX_WIDTH       = 4096;
    localparam int CH_MAX          = 255;
    localparam int WIDTH_FIELD_MAX = (1 << IMG_W) - 1;
    localparam int COL_MAX         = (1 << COL_W) - 1;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int HOLD_AT         = 300;
    localparam int HOLD_CYCLES     = 200;
    localparam int TAIL_CYCLES     = 16;
    localparam int WATCHDOG_LIMIT  = 2000;

    // Register addresses; the spare one lies just past the last register.
    localparam logic [PADDR_W-1:0] ADDR_WIDTH = {REG_IMAGE_WIDTH, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_LEFT  = {REG_LEFT_RGB, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_RIGHT = {REG_RIGHT_RGB, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_SPARE = 4'hC;

    typedef struct packed {
        bit                 is_write;
        logic [PADDR_W-1:0] addr;
        logic [APB_DW-1:0]  data;
        logic [COL_W-1:0]   column;
        bit                 typed;
        logic [PIX_W-1:0]   pixel;
    } t_row;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [PIX_W-1:0] pixel;
    } t_expect;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_column_valid;
    logic               o_column_ready;
    logic [COL_W-1:0]   i_column;
    logic               o_pixel_valid;
    logic               i_pixel_ready;
    logic [PIX_W-1:0]   o_pixel_argb;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    // Shadow copy of the configuration registers.
    logic [IMG_W-1:0] cfg_width;
    logic [RGB_W-1:0] cfg_left;
    logic [RGB_W-1:0] cfg_right;

    t_expect     pending_pixels [$];
    t_row        plan [$];
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    bit          calm;

    horizontal_gradient_pixel_generator #(
        .MAX_WIDTH(MAX_WIDTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_column_valid (i_column_valid),
        .o_column_ready (o_column_ready),
        .i_column       (i_column),
        .o_pixel_valid  (o_pixel_valid),
        .i_pixel_ready  (i_pixel_ready),
        .o_pixel_argb   (o_pixel_argb),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Clock generation.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Expected pixel for a column under the current register settings.
    function automatic logic [PIX_W-1:0] gradient_pixel(input logic [COL_W-1:0] col);
        int unsigned      span;
        int unsigned      weight;
        int unsigned      lo;
        int unsigned      hi;
        logic [PIX_W-1:0] pix;
        span = cfg_width;
        if (span == 0) span = 1;
        if (span > MAX_WIDTH) span = MAX_WIDTH;
        weight = 0;
        if (span > 1) begin
            weight = (int'(col) * CH_MAX) / (span - 1);
            if (weight > CH_MAX) weight = CH_MAX;
        end
        pix[PIX_W-1 -: CH_W] = ALPHA_OPAQUE;
        for (int ch = 0; ch < N_CH; ch++) begin
            lo = cfg_left[ch*CH_W +: CH_W];
            hi = cfg_right[ch*CH_W +: CH_W];
            pix[ch*CH_W +: CH_W] = CH_W'((lo * (CH_MAX - weight) + hi * weight) / CH_MAX);
        end
        return pix;
    endfunction

    function automatic t_row reg_row(input logic [PADDR_W-1:0] addr,
                                     input logic [APB_DW-1:0] data);
        t_row row;
        row = '0;
        row.is_write = 1'b1;
        row.addr     = addr;
        row.data     = data;
        return row;
    endfunction

    function automatic t_row col_row(input logic [COL_W-1:0] col);
        t_row row;
        row = '0;
        row.column = col;
        return row;
    endfunction

    function automatic t_row known_row(input logic [COL_W-1:0] col,
                                       input logic [PIX_W-1:0] pix);
        t_row row;
        row = col_row(col);
        row.typed = 1'b1;
        row.pixel = pix;
        return row;
    endfunction

    // One register write: setup cycle, access cycle, then a cycle with the port released.
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (t_reg_idx'(addr[3:2]))
            REG_IMAGE_WIDTH: cfg_width = data[IMG_W-1:0];
            REG_LEFT_RGB:    cfg_left  = data[RGB_W-1:0];
            REG_RIGHT_RGB:   cfg_right = data[RGB_W-1:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offers one column request and records the pixel it should produce.
    task automatic offer_column(input logic [COL_W-1:0] col, input bit typed,
                                input logic [PIX_W-1:0] pix);
        t_expect e;
        if (!calm) begin
            while ($urandom_range(0, 99) < 25) begin
                i_column_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_column_valid <= 1'b1;
        i_column       <= col;
        @(posedge i_clk);
        while (!o_column_ready) @(posedge i_clk);
        e.column = col;
        e.pixel  = typed ? pix : gradient_pixel(col);
        pending_pixels.push_back(e);
    endtask

    // Stops offering and waits until every expected pixel has come back.
    task automatic wait_idle();
        i_column_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    // Pixel receiver: random stalls, plus one long hold-off that backs up the pipeline.
    initial begin : pixel_sink
        int unsigned seen;
        bit          held;
        seen = 0;
        held = 1'b0;
        i_pixel_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_pixel_valid && i_pixel_ready) seen++;
            if (!held && seen == HOLD_AT) begin
                held = 1'b1;
                i_pixel_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_pixel_ready <= calm || ($urandom_range(0, 99) >= 25);
        end
    end

    // Compare each delivered pixel with the oldest expectation.
    always @(posedge i_clk) begin : check_pixels
        t_expect e;
        if (i_rst_n && o_pixel_valid && i_pixel_ready) begin
            if (pending_pixels.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected pixel: expected none, got %h", $time, o_pixel_argb);
            end else begin
                e = pending_pixels.pop_front();
                if (o_pixel_argb !== e.pixel) begin
                    mismatches++;
                    $display("%0t: column %0d: expected %h, got %h",
                             $time, e.column, e.pixel, o_pixel_argb);
                end
            end
        end
    end

    // Watchdog on cycles with no traffic at all.
    always @(posedge i_clk) begin
        if ((i_column_valid && o_column_ready) || (o_pixel_valid && i_pixel_ready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("horizontal_gradient_pixel_generator_tb NOT OK");
            $finish;
        end
    end

    initial begin : main
        int unsigned span;
        int unsigned top;
        t_row        row;

        i_rst_n        = 1'b0;
        i_column_valid = 1'b0;
        i_column       = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        calm           = 1'b0;
        cfg_width      = WIDTH_RST;
        cfg_left       = LEFT_RST;
        cfg_right      = RIGHT_RST;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset state: width of one, so every column is the black left color.
        plan.push_back(known_row(12'd0, 32'hFF000000));
        plan.push_back(known_row(12'hFFF, 32'hFF000000));
        plan.push_back(known_row(12'hAAA, 32'hFF000000));
        // Two columns: column one is already the right color, and so is anything past it.
        plan.push_back(reg_row(ADDR_LEFT, 32'h00102030));
        plan.push_back(reg_row(ADDR_RIGHT, 32'h00C0D0E0));
        plan.push_back(reg_row(ADDR_WIDTH, 32'd2));
        plan.push_back(known_row(12'd0, 32'hFF102030));
        plan.push_back(known_row(12'd1, 32'hFFC0D0E0));
        plan.push_back(known_row(12'hFFF, 32'hFFC0D0E0));
        // A width of zero behaves as a width of one.
        plan.push_back(reg_row(ADDR_WIDTH, 32'd0));
        plan.push_back(known_row(12'hFFF, 32'hFF102030));
        plan.push_back(known_row(12'd0, 32'hFF102030));
        // The largest field value saturates to the maximum width.
        plan.push_back(reg_row(ADDR_WIDTH, WIDTH_FIELD_MAX));
        plan.push_back(known_row(12'hFFF, 32'hFFC0D0E0));
        plan.push_back(known_row(12'd0, 32'hFF102030));
        plan.push_back(col_row(12'd2048));
        // Upper data bits are dropped, leaving exactly the maximum width.
        plan.push_back(reg_row(ADDR_WIDTH, 32'hFFFFF000));
        plan.push_back(known_row(12'hFFF, 32'hFFC0D0E0));
        plan.push_back(col_row(12'd2047));
        plan.push_back(col_row(12'd1));
        // White to black, with the unused color byte set on both writes.
        plan.push_back(reg_row(ADDR_LEFT, 32'hFFFFFFFF));
        plan.push_back(reg_row(ADDR_RIGHT, 32'hFF000000));
        plan.push_back(known_row(12'd0, 32'hFFFFFFFF));
        plan.push_back(known_row(12'hFFF, 32'hFF000000));
        // A write past the last register changes nothing.
        plan.push_back(reg_row(ADDR_SPARE, 32'h00000000));
        plan.push_back(known_row(12'd0, 32'hFFFFFFFF));
        plan.push_back(reg_row(ADDR_WIDTH, 32'd1000));
        plan.push_back(col_row(12'd500));
        plan.push_back(col_row(12'd999));
        plan.push_back(col_row(12'd1000));
        plan.push_back(known_row(12'hFFF, 32'hFF000000));

        foreach (plan[i]) begin
            row = plan[i];
            if (row.is_write) begin
                wait_idle();
                apb_write(row.addr, row.data);
            end else begin
                offer_column(row.column, row.typed, row.pixel);
            end
        end

        // Random phases: new colors and width each time, then a burst of columns.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            calm = (ph == 4 || ph == 5);
            case ($urandom_range(0, 7))
                0: span = $urandom_range(0, 2);
                1: span = $urandom_range(MAX_WIDTH + 1, WIDTH_FIELD_MAX);
                2: span = MAX_WIDTH;
                default: span = $urandom_range(3, MAX_WIDTH);
            endcase
            apb_write(ADDR_LEFT, $urandom);
            apb_write(ADDR_RIGHT, $urandom);
            apb_write(ADDR_WIDTH, ($urandom & ~32'(WIDTH_FIELD_MAX)) | span);
            top = (span > COL_MAX) ? COL_MAX : span;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 1) == 1)
                    offer_column(COL_W'($urandom_range(0, top)), 1'b0, '0);
                else
                    offer_column(COL_W'($urandom), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("horizontal_gradient_pixel_generator_tb OK");
        end else begin
            $display("horizontal_gradient_pixel_generator_tb NOT OK");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/hgpg_pkg.sv
src/hgpg_tdiv.sv
src/horizontal_gradient_pixel_generator.sv
tb/sv/horizontal_gradient_pixel_generator_tb.sv
